[src/dtqg_pkg.sv]
// Shared constants, micro-op codes, status type and tone table for the DTMF tone queue.
package dtqg_pkg;

    localparam int QUEUE_DEPTH_DEF = 256;

    // Fade divider: 43 dividend bits, one quotient bit per step
    localparam int DIV_STEPS  = 43;
    localparam int RATE_HZ    = 44100;

    // Tone phase by reciprocal multiplication, exact over the operand ranges used:
    // floor(x / 44100) = (x * RATE_RECIP) >> RATE_SHIFT for x < 2^27
    // floor(m * 65536 / 44100) = (m * TURN_RECIP) >> TURN_SHIFT for m < 44100
    localparam int RATE_RECIP = 199457892;
    localparam int RATE_SHIFT = 43;
    localparam int TURN_RECIP = 797831567;
    localparam int TURN_SHIFT = 29;

    // Sine polynomial coefficients (Q14 argument, Q15 result)
    localparam int SIN_A      = 2320;
    localparam int SIN_B      = 21024;
    localparam int SIN_C      = 51472;
    localparam int QUARTER    = 16384;
    localparam int ROUND_Q15  = 16384;
    localparam int MIX_GAIN   = 13107;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    localparam logic REQ_PUT  = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    localparam logic REG_TONE = 1'b0;
    localparam logic REG_FADE = 1'b1;

    typedef logic [4:0] t_op;

    localparam t_op OP_NOP      = 5'd0;
    localparam t_op OP_CAPTURE  = 5'd1;
    localparam t_op OP_ENQ      = 5'd2;
    localparam t_op OP_ZERO     = 5'd3;
    localparam t_op OP_START    = 5'd4;
    localparam t_op OP_NF       = 5'd5;
    localparam t_op OP_PH_QUO   = 5'd6;
    localparam t_op OP_DIV_FOUT = 5'd7;
    localparam t_op OP_DIV_FIN  = 5'd8;
    localparam t_op OP_DIV_STEP = 5'd9;
    localparam t_op OP_SIN_XT   = 5'd10;
    localparam t_op OP_SIN_XF   = 5'd11;
    localparam t_op OP_SIN_XX   = 5'd12;
    localparam t_op OP_SIN_T1   = 5'd13;
    localparam t_op OP_SIN_T2   = 5'd14;
    localparam t_op OP_SIN_T3   = 5'd15;
    localparam t_op OP_SIN_ST   = 5'd16;
    localparam t_op OP_SIN_SF   = 5'd17;
    localparam t_op OP_MIX_MUL  = 5'd18;
    localparam t_op OP_MIX_RND  = 5'd19;
    localparam t_op OP_FADE_MUL = 5'd20;
    localparam t_op OP_FADE_RND = 5'd21;
    localparam t_op OP_FINISH   = 5'd22;
    localparam t_op OP_PH_MOD   = 5'd23;
    localparam t_op OP_PH_TURN  = 5'd24;

    typedef struct packed {
        logic req_tick;
        logic empty;
        logic div_last;
        logic col;
        logic fo_need;
        logic fi_need;
        logic out_valid;
    } t_dp_stat;

    // Row tone for digit/4, column tone for digit%4
    function automatic logic [10:0] tone_freq(input logic [3:0] d, input logic col);
        logic [1:0] sel;
        logic [10:0] f;
        sel = col ? d[1:0] : d[3:2];
        f = '0;
        if (col) begin
            case (sel)
                2'd0: f = 11'd1209;
                2'd1: f = 11'd1336;
                2'd2: f = 11'd1477;
                default: f = 11'd1633;
            endcase
        end else begin
            case (sel)
                2'd0: f = 11'd697;
                2'd1: f = 11'd770;
                2'd2: f = 11'd852;
                default: f = 11'd941;
            endcase
        end
        return f;
    endfunction

endpackage

[src/dtqg_ctrl.sv]
// Sequencer for the DTMF tone queue: issues one datapath micro-op per cycle.
module dtqg_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  dtqg_pkg::t_dp_stat i_stat,
    output dtqg_pkg::t_op      o_op
);
    import dtqg_pkg::*;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_DECODE = 5'd1;
    localparam logic [4:0] S_NF     = 5'd2;
    localparam logic [4:0] S_PHQ    = 5'd3;
    localparam logic [4:0] S_DIV    = 5'd4;
    localparam logic [4:0] S_SX     = 5'd5;
    localparam logic [4:0] S_SXX    = 5'd6;
    localparam logic [4:0] S_ST1    = 5'd7;
    localparam logic [4:0] S_ST2    = 5'd8;
    localparam logic [4:0] S_ST3    = 5'd9;
    localparam logic [4:0] S_SS     = 5'd10;
    localparam logic [4:0] S_MIX    = 5'd11;
    localparam logic [4:0] S_MIXR   = 5'd12;
    localparam logic [4:0] S_FOLD   = 5'd13;
    localparam logic [4:0] S_FILD   = 5'd14;
    localparam logic [4:0] S_FMUL   = 5'd15;
    localparam logic [4:0] S_FRND   = 5'd16;
    localparam logic [4:0] S_FIN    = 5'd17;
    localparam logic [4:0] S_PHM    = 5'd18;
    localparam logic [4:0] S_PHT    = 5'd19;

    logic [4:0] r_state, n_state;
    logic       r_fmode, n_fmode;   // sine unit is evaluating a fade cosine
    logic       r_fout, n_fout;     // fade-out was just applied

    always_comb begin
        n_state    = r_state;
        n_fmode    = r_fmode;
        n_fout     = r_fout;
        o_op       = OP_NOP;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = !i_stat.out_valid;
                if (i_s_tvalid && !i_stat.out_valid) begin
                    o_op    = OP_CAPTURE;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_fmode = 1'b0;
                n_fout  = 1'b0;
                if (!i_stat.req_tick) begin
                    o_op    = OP_ENQ;
                    n_state = S_IDLE;
                end else if (i_stat.empty) begin
                    o_op    = OP_ZERO;
                    n_state = S_IDLE;
                end else begin
                    o_op    = OP_START;
                    n_state = S_NF;
                end
            end
            S_NF: begin
                o_op    = OP_NF;
                n_state = S_PHQ;
            end
            S_PHQ: begin
                o_op    = OP_PH_QUO;
                n_state = S_PHM;
            end
            S_PHM: begin
                o_op    = OP_PH_MOD;
                n_state = S_PHT;
            end
            S_PHT: begin
                o_op    = OP_PH_TURN;
                n_state = S_SX;
            end
            S_FOLD: begin
                o_op    = OP_DIV_FOUT;
                n_fmode = 1'b1;
                n_fout  = 1'b1;
                n_state = S_DIV;
            end
            S_FILD: begin
                o_op    = OP_DIV_FIN;
                n_fmode = 1'b1;
                n_fout  = 1'b0;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_op = OP_DIV_STEP;
                if (i_stat.div_last) n_state = S_SX;
            end
            S_SX: begin
                o_op    = r_fmode ? OP_SIN_XF : OP_SIN_XT;
                n_state = S_SXX;
            end
            S_SXX: begin
                o_op    = OP_SIN_XX;
                n_state = S_ST1;
            end
            S_ST1: begin
                o_op    = OP_SIN_T1;
                n_state = S_ST2;
            end
            S_ST2: begin
                o_op    = OP_SIN_T2;
                n_state = S_ST3;
            end
            S_ST3: begin
                o_op    = OP_SIN_T3;
                n_state = S_SS;
            end
            S_SS: begin
                if (r_fmode) begin
                    o_op    = OP_SIN_SF;
                    n_state = S_FMUL;
                end else begin
                    o_op    = OP_SIN_ST;
                    n_state = i_stat.col ? S_MIX : S_NF;
                end
            end
            S_MIX: begin
                o_op    = OP_MIX_MUL;
                n_state = S_MIXR;
            end
            S_MIXR: begin
                o_op = OP_MIX_RND;
                if (i_stat.fo_need)      n_state = S_FOLD;
                else if (i_stat.fi_need) n_state = S_FILD;
                else                     n_state = S_FIN;
            end
            S_FMUL: begin
                o_op    = OP_FADE_MUL;
                n_state = S_FRND;
            end
            S_FRND: begin
                o_op    = OP_FADE_RND;
                n_state = (r_fout && i_stat.fi_need) ? S_FILD : S_FIN;
            end
            S_FIN: begin
                o_op    = OP_FINISH;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fmode <= 1'b0;
            r_fout  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fmode <= n_fmode;
            r_fout  <= n_fout;
        end
    end

endmodule

[src/dtqg_dp.sv]
// Datapath of the DTMF tone queue: digit ring, divider, sine unit, mixer and output register.
module dtqg_dp #(
    parameter int QUEUE_DEPTH = dtqg_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dtqg_pkg::t_op      i_op,
    output dtqg_pkg::t_dp_stat o_stat,
    input  logic               i_cfg_wr_en,
    input  logic               i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_s_tuser,
    input  logic [7:0]         i_s_tdata,
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [23:0]        o_m_tdata
);
    import dtqg_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);

    logic [3:0]        r_ring [QUEUE_DEPTH];
    logic [3:0]        r_head;
    logic [IDX_W-1:0]  r_wr, r_rd;
    logic [15:0]       r_n;
    logic [15:0]       r_tone;
    logic [13:0]       r_fade;
    logic              r_req;
    logic [7:0]        r_din;
    logic              r_sel;
    logic [33:0]       r_prod;
    logic [14:0]       r_x, r_x2;
    logic              r_neg;
    logic signed [17:0] r_acc;
    logic [15:0]       r_mag;
    logic              r_rneg;
    logic [16:0]       r_g;
    logic [42:0]       r_dvd;
    logic [15:0]       r_dvs, r_rem, r_quo;
    logic [5:0]        r_cnt;
    logic [11:0]       r_q;
    logic [15:0]       r_m;
    logic              r_out_valid;
    logic [1:0]        r_status;
    logic [15:0]       r_sample;

    logic [IDX_W-1:0]  wr_next, rd_next;
    logic              full, bad;
    logic signed [17:0] n_s, begin_s, k_out;
    logic [15:0]       k_in;
    logic [16:0]       rem_sh, rem_nx;
    logic              ge;
    logic [15:0]       turn;
    logic [14:0]       x_c, x2_c;
    logic [16:0]       t1, t2, s_c, acc_mag;
    logic [33:0]       rnd;
    logic [16:0]       mul_a, mul_b;
    logic [33:0]       prod_c;
    logic [15:0]       n1;
    logic [54:0]       qprod_c;
    logic [26:0]       qmul_c;
    logic [44:0]       tprod_c;

    assign wr_next = (r_wr == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign rd_next = (r_rd == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
    assign full    = (wr_next == r_rd);
    assign bad     = (r_din > 8'd15);

    // Fade windows: the tail starts at tone - fade, which may be negative
    assign n_s     = $signed({2'b00, r_n});
    assign begin_s = $signed({2'b00, r_tone}) - $signed({4'b0000, r_fade});
    assign k_out   = n_s - begin_s;
    assign k_in    = {2'b00, r_fade} - r_n;

    // One restoring division step
    assign rem_sh = {r_rem, r_dvd[42]};
    assign ge     = (rem_sh >= {1'b0, r_dvs});
    assign rem_nx = ge ? rem_sh - {1'b0, r_dvs} : rem_sh;

    // Tone phase: quotient of n*f by the sample rate, remainder, then 16-bit turn
    assign qprod_c = 55'(r_prod[26:0]) * 55'(RATE_RECIP);
    assign qmul_c  = 27'(r_q) * 27'(RATE_HZ);
    assign tprod_c = 45'(r_m) * 45'(TURN_RECIP);

    // Cosine is the sine a quarter turn ahead
    assign turn = (i_op == OP_SIN_XF) ? r_quo + 16'(QUARTER) : r_quo;
    assign x_c  = turn[14] ? 15'(QUARTER) - {1'b0, turn[13:0]} : {1'b0, turn[13:0]};
    assign x2_c = r_prod[28:14];
    assign t1   = 17'(SIN_B) - r_prod[30:14];
    assign t2   = 17'(SIN_C) - r_prod[30:14];
    assign s_c  = r_prod[30:14];

    assign acc_mag = r_acc[17] ? 17'(-r_acc) : 17'(r_acc);
    assign rnd     = r_prod + 34'(ROUND_Q15);
    assign n1      = r_n + 16'd1;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_op)
            OP_NF: begin
                mul_a = {1'b0, r_n};
                mul_b = {6'b0, tone_freq(r_head, r_sel)};
            end
            OP_SIN_XX: begin
                mul_a = {2'b0, r_x};
                mul_b = {2'b0, r_x};
            end
            OP_SIN_T1: begin
                mul_a = 17'(SIN_A);
                mul_b = {2'b0, x2_c};
            end
            OP_SIN_T2: begin
                mul_a = t1;
                mul_b = {2'b0, r_x2};
            end
            OP_SIN_T3: begin
                mul_a = t2;
                mul_b = {2'b0, r_x};
            end
            OP_MIX_MUL: begin
                mul_a = acc_mag;
                mul_b = 17'(MIX_GAIN);
            end
            OP_FADE_MUL: begin
                mul_a = {1'b0, r_mag};
                mul_b = r_g;
            end
            default: ;
        endcase
    end

    assign prod_c = mul_a * mul_b;

    // Ring storage: write on accepted put, read head every cycle
    always_ff @(posedge i_clk) begin
        if (i_op == OP_ENQ && !bad && !full) r_ring[r_wr] <= r_din[3:0];
        r_head <= r_ring[r_rd];
    end

    // Arithmetic payload registers
    always_ff @(posedge i_clk) begin
        unique case (i_op)
            OP_CAPTURE: begin
                r_req <= i_s_tuser;
                r_din <= i_s_tdata;
            end
            OP_START: begin
                r_acc <= '0;
                r_sel <= 1'b0;
            end
            OP_NF, OP_SIN_XX, OP_SIN_T2, OP_SIN_T3, OP_MIX_MUL, OP_FADE_MUL: begin
                r_prod <= prod_c;
            end
            OP_SIN_T1: begin
                r_x2   <= x2_c;
                r_prod <= prod_c;
            end
            OP_PH_QUO: begin
                r_q <= qprod_c[54:RATE_SHIFT];
            end
            OP_PH_MOD: begin
                r_m <= 16'(r_prod[26:0] - qmul_c);
            end
            OP_PH_TURN: begin
                r_quo <= tprod_c[TURN_SHIFT+15:TURN_SHIFT];
            end
            OP_DIV_FOUT: begin
                r_dvd <= {11'b0, k_out[16:0], 15'b0};
                r_dvs <= {2'b0, r_fade};
                r_rem <= '0;
                r_cnt <= 6'(DIV_STEPS);
            end
            OP_DIV_FIN: begin
                r_dvd <= {11'b0, 1'b0, k_in, 15'b0};
                r_dvs <= {2'b0, r_fade};
                r_rem <= '0;
                r_cnt <= 6'(DIV_STEPS);
            end
            OP_DIV_STEP: begin
                r_dvd <= {r_dvd[41:0], 1'b0};
                r_rem <= rem_nx[15:0];
                r_quo <= {r_quo[14:0], ge};
                r_cnt <= r_cnt - 6'd1;
            end
            OP_SIN_XT, OP_SIN_XF: begin
                r_x   <= x_c;
                r_neg <= turn[15];
            end
            OP_SIN_ST: begin
                r_acc <= r_neg ? r_acc - $signed({1'b0, s_c}) : r_acc + $signed({1'b0, s_c});
                r_sel <= 1'b1;
            end
            OP_SIN_SF: begin
                // gain = 1/2 + cos/2, halving toward zero
                r_g <= r_neg ? 17'(QUARTER) - {1'b0, s_c[16:1]}
                             : 17'(QUARTER) + {1'b0, s_c[16:1]};
            end
            OP_MIX_RND: begin
                r_mag  <= rnd[30:15];
                r_rneg <= r_acc[17];
            end
            OP_FADE_RND: begin
                r_mag <= rnd[30:15];
            end
            default: ;
        endcase
    end

    // Control state: indices, sample counter, configuration, output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr        <= '0;
            r_rd        <= '0;
            r_n         <= '0;
            r_tone      <= 16'd4410;
            r_fade      <= 14'd882;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                if (i_cfg_idx == REG_FADE) r_fade <= i_cfg_data[13:0];
                else                       r_tone <= i_cfg_data;
            end
            if (r_out_valid && i_m_tready) r_out_valid <= 1'b0;
            case (i_op)
                OP_ENQ: begin
                    r_out_valid <= 1'b1;
                    r_sample    <= '0;
                    if (bad) begin
                        r_status <= ST_BAD;
                    end else if (full) begin
                        r_status <= ST_FULL;
                    end else begin
                        r_status <= ST_OK;
                        r_wr     <= wr_next;
                    end
                end
                OP_ZERO: begin
                    r_out_valid <= 1'b1;
                    r_status    <= ST_OK;
                    r_sample    <= '0;
                end
                OP_FINISH: begin
                    r_out_valid <= 1'b1;
                    r_status    <= ST_OK;
                    r_sample    <= r_rneg ? 16'(-r_mag) : r_mag;
                    if (n1 == r_tone) begin
                        r_n  <= '0;
                        r_rd <= rd_next;
                    end else begin
                        r_n <= n1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_stat.req_tick  = (r_req == REQ_TICK);
    assign o_stat.empty     = (r_rd == r_wr);
    assign o_stat.div_last  = (r_cnt == 6'd1);
    assign o_stat.col       = r_sel;
    assign o_stat.fo_need   = (r_fade != '0) && (n_s > begin_s);
    assign o_stat.fi_need   = (r_n < {2'b00, r_fade});
    assign o_stat.out_valid = r_out_valid;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'b0, r_sample, r_status};

endmodule

[src/dtmf_tone_queue_generator_unit.sv]
// Top level of the DTMF tone queue generator: sequencer plus datapath.
//
//  channel  dir  handshake                 payload
//  s        in   i_s_tvalid / o_s_tready   tuser: req_type; tdata: digit
//  m        out  o_m_tvalid / i_m_tready   tdata: status, sample
//  cfg      in   i_cfg_wr_en               i_cfg_idx, i_cfg_data
//
// A put, or a tick on an empty queue, is answered from decode; a tick with a
// queued digit goes on through both tone phases, the sine unit and the mix, and
// through a division and a fade gain for each active fade (fade-in, fade-out).
// Each tone phase uses reciprocal multiplies in place of the rate division;
// each fade is set by the 43-step serial divider for k*32768/fade.
// One item is in flight at a time; the input stalls while a result waits.
// Reset is synchronous and active low; it empties the queue and restores
// tone_samples = 4410 and fade_samples = 882. The ring needs no clearing.
module dtmf_tone_queue_generator_unit #(
    parameter int QUEUE_DEPTH = dtqg_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] digit
    input  logic        i_s_tuser,   // [0] req_type: 0 put digit, 1 sample tick
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [1:0] status, [17:2] sample, [23:18] zero
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_idx,   // 0 tone_samples, 1 fade_samples
    input  logic [15:0] i_cfg_data
);
    import dtqg_pkg::*;

    t_op      op;
    t_dp_stat stat;

    // Sequencer: one micro-op per cycle
    dtqg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_op       (op)
    );

    // Datapath: ring, phase, divider, sine polynomial, mix and fade gain
    dtqg_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (op),
        .o_stat      (stat),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_s_tuser   (i_s_tuser),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

endmodule

[src/dtqg_chk.sv]
// Port-level checks for the DTMF tone queue generator, bound to the top level.
module dtqg_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [7:0]  i_s_tdata,
    input logic        i_s_tuser,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [23:0] o_m_tdata
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // Take no new item while a result waits
    a_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !o_s_tready)
        else $error("input ready while result pending");

    // Status code 3 is never produced
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[1:0] != 2'd3)
        else $error("undefined status");

    // A refused put carries a zero sample
    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[1:0] != 2'd0 |-> o_m_tdata[17:2] == 16'd0)
        else $error("nonzero sample on refused put");

    // A put of a digit above 15 answers invalid once the digit is captured and decoded
    a_bad_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && !i_s_tuser && i_s_tdata > 8'd15
        |=> ##1 o_m_tvalid && o_m_tdata[1:0] == 2'd2)
        else $error("invalid digit not flagged");

endmodule

bind dtmf_tone_queue_generator_unit dtqg_chk u_chk (.*);
